// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define BFPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check, also live during reset
`define BFPU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/bfpu_pkg.sv =====
package bfpu_pkg;

    localparam int STORE_BITS = 1024;
    localparam int ADDR_W     = $clog2(STORE_BITS);
    localparam int CNT_W      = $clog2(STORE_BITS + 1);

    localparam int OP_W       = 4;
    localparam int VALUE_W    = 64;
    localparam int START_W    = 10;
    localparam int WIDTH_W    = 7;
    localparam int NLEN_W     = 11;
    localparam int STATUS_W   = 2;

    localparam int POS_W      = (CNT_W > NLEN_W) ? CNT_W : NLEN_W;
    localparam int SUM_W      = POS_W + 1;

    localparam int IN_W       = OP_W + VALUE_W + START_W + WIDTH_W + NLEN_W;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W      = VALUE_W + STATUS_W + CNT_W;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_CLEAR    = 4'd0;
    localparam t_op OP_APPEND_U = 4'd1;
    localparam t_op OP_APPEND_S = 4'd2;
    localparam t_op OP_GET_U    = 4'd3;
    localparam t_op OP_GET_S    = 4'd4;
    localparam t_op OP_GET_SM   = 4'd5;
    localparam t_op OP_INSERT   = 4'd6;
    localparam t_op OP_INVERT   = 4'd7;
    localparam t_op OP_SET_LEN  = 4'd8;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_BEYOND = 2'd1;
    localparam t_status ST_WIDE   = 2'd2;
    localparam t_status ST_FULL   = 2'd3;

    function automatic logic [VALUE_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [VALUE_W-1:0] m;
        if (w >= WIDTH_W'(VALUE_W)) begin
            m = '1;
        end else begin
            m = ~({VALUE_W{1'b1}} << w);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/bit_field_pack_unpack_store_unit.sv =====
// Clear, invert, set length and rejected operations go from the check state straight to
// the output state; append and insert first write the field, gets first read it and then format it.
// One bit of the store is read or written per cycle through a single memory port.
// A new transaction is taken only once the last one is done: the input is taken again as
// soon as the result sits in the output register.
// Reset (synchronous, active low) empties the store; store contents are not cleared.
module bit_field_pack_unpack_store_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation, value, start_bit, field_width, new_length
    input  logic [bfpu_pkg::IN_BYTES_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // data, status, stored_len, zero pad
    output logic [bfpu_pkg::OUT_BYTES_W-1:0]    m_axis_tdata
);

    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int VW = bfpu_pkg::VALUE_W;
    localparam int WW = bfpu_pkg::WIDTH_W;

    logic [2:0]                    r_state;
    logic [bfpu_pkg::CNT_W-1:0]    r_count;
    logic                          r_inv;
    logic                          r_o_vld;
    logic                          r_pend;
    logic [WW-1:0]                 r_cnt;

    bfpu_pkg::t_op                 r_op;
    logic [VW-1:0]                 r_value;
    logic [bfpu_pkg::START_W-1:0]  r_start;
    logic [WW-1:0]                 r_w;
    logic [bfpu_pkg::NLEN_W-1:0]   r_nlen;
    logic [bfpu_pkg::POS_W-1:0]    r_pos;
    logic [VW-1:0]                 r_acc;
    logic [VW-1:0]                 r_data;
    bfpu_pkg::t_status             r_status;
    logic                          r_rd_bit;
    logic [VW-1:0]                 r_o_data;
    bfpu_pkg::t_status             r_o_status;
    logic [bfpu_pkg::CNT_W-1:0]    r_o_count;

    logic                          mem [0:bfpu_pkg::STORE_BITS-1];

    logic                          accept;
    logic                          out_load;
    logic [VW-1:0]                 w_mask;
    logic [VW-1:0]                 w_mask_m1;
    logic [VW-1:0]                 hi_bits;
    logic                          wok;
    logic                          u_wide;
    logic                          s_wide;
    logic [bfpu_pkg::SUM_W-1:0]    get_end;
    logic [bfpu_pkg::SUM_W-1:0]    app_end;
    logic [bfpu_pkg::SUM_W-1:0]    count_ext;
    logic                          in_bounds;
    logic                          full;
    logic [bfpu_pkg::SUM_W-1:0]    addr_sum;
    logic [bfpu_pkg::ADDR_W-1:0]   mem_addr;
    logic                          wbit;
    logic                          issue;
    logic                          mem_we;
    logic                          sign;
    logic [VW-1:0]                 mag;
    logic [VW-1:0]                 fin_data;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_o_vld || m_axis_tready);

    always_comb begin
        w_mask    = bfpu_pkg::width_mask(r_w);
        w_mask_m1 = bfpu_pkg::width_mask(r_w - WW'(1));
        wok       = (r_w != '0) && (r_w <= WW'(VW));
        u_wide    = |(r_value & ~w_mask);
        hi_bits   = r_value & ~w_mask_m1;
        s_wide    = (r_w != WW'(VW)) && (hi_bits != '0) && (hi_bits != ~w_mask_m1);
        count_ext = bfpu_pkg::SUM_W'(r_count);
        get_end   = bfpu_pkg::SUM_W'(r_start) + bfpu_pkg::SUM_W'(r_w);
        app_end   = count_ext + bfpu_pkg::SUM_W'(r_w);
        in_bounds = wok && (get_end <= count_ext);
        full      = app_end > bfpu_pkg::SUM_W'(bfpu_pkg::STORE_BITS);
        addr_sum  = bfpu_pkg::SUM_W'(r_pos) + bfpu_pkg::SUM_W'(r_cnt);
        mem_addr  = addr_sum[bfpu_pkg::ADDR_W-1:0];
        wbit      = r_value[6'(r_w - WW'(1) - r_cnt)] ^ r_inv;
        issue     = (r_state == S_READ) && (r_cnt < r_w);
        mem_we    = (r_state == S_WRITE);
        sign      = r_acc[6'(r_w - WW'(1))];
        mag       = r_acc & w_mask_m1;
        case (r_op)
            bfpu_pkg::OP_GET_S: begin
                fin_data = (sign && (r_w != WW'(VW))) ? (r_acc | ~w_mask) : r_acc;
            end
            bfpu_pkg::OP_GET_SM: begin
                fin_data = sign ? (VW'(0) - mag) : mag;
            end
            default: begin
                fin_data = r_acc;
            end
        endcase
    end

    // bit store, stored inverted when the invert flag is set
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= wbit;
        end
        r_rd_bit <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_inv   <= 1'b0;
            r_o_vld <= 1'b0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (out_load) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
            r_pend <= issue;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_cnt <= '0;
                    case (r_op)
                        bfpu_pkg::OP_CLEAR: begin
                            r_count <= '0;
                            r_state <= S_OUT;
                        end
                        bfpu_pkg::OP_APPEND_U, bfpu_pkg::OP_APPEND_S: begin
                            if (wok && !((r_op == bfpu_pkg::OP_APPEND_U) && u_wide)
                                    && !((r_op == bfpu_pkg::OP_APPEND_S) && s_wide)
                                    && !full) begin
                                r_count <= app_end[bfpu_pkg::CNT_W-1:0];
                                r_state <= S_WRITE;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        bfpu_pkg::OP_GET_U, bfpu_pkg::OP_GET_S, bfpu_pkg::OP_GET_SM: begin
                            r_state <= in_bounds ? S_READ : S_OUT;
                        end
                        bfpu_pkg::OP_INSERT: begin
                            r_state <= (in_bounds && !u_wide) ? S_WRITE : S_OUT;
                        end
                        bfpu_pkg::OP_INVERT: begin
                            r_inv   <= ~r_inv;
                            r_state <= S_OUT;
                        end
                        bfpu_pkg::OP_SET_LEN: begin
                            if (bfpu_pkg::SUM_W'(r_nlen) <= count_ext) begin
                                r_count <= r_nlen[bfpu_pkg::CNT_W-1:0];
                            end
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_WRITE: begin
                    r_cnt <= r_cnt + WW'(1);
                    if (r_cnt == r_w - WW'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_READ: begin
                    if (issue) begin
                        r_cnt <= r_cnt + WW'(1);
                    end else if (r_pend) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= s_axis_tdata[3:0];
            r_value <= s_axis_tdata[67:4];
            r_start <= s_axis_tdata[77:68];
            r_w     <= s_axis_tdata[84:78];
            r_nlen  <= s_axis_tdata[95:85];
        end
        if (r_pend) begin
            r_acc <= {r_acc[VW-2:0], r_rd_bit ^ r_inv};
        end
        if (r_state == S_CHECK) begin
            r_acc  <= '0;
            r_data <= '0;
            case (r_op)
                bfpu_pkg::OP_APPEND_U, bfpu_pkg::OP_APPEND_S: begin
                    r_pos <= bfpu_pkg::POS_W'(r_count);
                    if (!wok || ((r_op == bfpu_pkg::OP_APPEND_U) && u_wide)
                            || ((r_op == bfpu_pkg::OP_APPEND_S) && s_wide)) begin
                        r_status <= bfpu_pkg::ST_WIDE;
                    end else if (full) begin
                        r_status <= bfpu_pkg::ST_FULL;
                    end else begin
                        r_status <= bfpu_pkg::ST_OK;
                    end
                end
                bfpu_pkg::OP_GET_U, bfpu_pkg::OP_GET_S, bfpu_pkg::OP_GET_SM: begin
                    r_pos    <= bfpu_pkg::POS_W'(r_start);
                    r_status <= in_bounds ? bfpu_pkg::ST_OK : bfpu_pkg::ST_BEYOND;
                end
                bfpu_pkg::OP_INSERT: begin
                    r_pos <= bfpu_pkg::POS_W'(r_start);
                    if (!in_bounds) begin
                        r_status <= wok ? bfpu_pkg::ST_BEYOND : bfpu_pkg::ST_WIDE;
                    end else if (u_wide) begin
                        r_status <= bfpu_pkg::ST_WIDE;
                    end else begin
                        r_status <= bfpu_pkg::ST_OK;
                    end
                end
                default: begin
                    r_status <= bfpu_pkg::ST_OK;
                end
            endcase
        end
        if (r_state == S_FIN) begin
            r_data <= fin_data;
        end
        if (out_load) begin
            r_o_data   <= r_data;
            r_o_status <= r_status;
            r_o_count  <= r_count;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {(bfpu_pkg::OUT_BYTES_W - bfpu_pkg::OUT_W)'(0),
                            r_o_count, r_o_status, r_o_data};

    `BFPU_ASSERT(a_count_cap, r_count <= bfpu_pkg::CNT_W'(bfpu_pkg::STORE_BITS), "bit count above capacity")
    `BFPU_ASSERT(a_read_len, (r_state == S_FIN) |-> (r_cnt == r_w), "field read ended early")
    `BFPU_ASSERT(a_out_src, $rose(r_o_vld) |-> ($past(r_state) == S_OUT), "result raised outside output step")

endmodule
